>>> rtl/assert_macros.svh
// assertion macros for the rtl of box_downscale_2x2
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold on every rising clock edge outside reset
`define BD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// condition must never be true outside reset
`define BD_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define BD_ASSERT(label, clk, rst, prop)
`define BD_NEVER(label, clk, rst, cond)
`endif
`endif

>>> rtl/bd2x2_pkg.sv
// types and constants of the 2x2 box downscaler
`default_nettype none
package bd2x2_pkg;

   // register indexes on the csr port
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_PIXEL_FORMAT = 2'd2;

   // pixel format codes
   localparam logic [1:0] FMT_RGBA       = 2'd0;
   localparam logic [1:0] FMT_GRAY_ALPHA = 2'd1;
   localparam logic [1:0] FMT_GRAY       = 2'd2;

   localparam logic [9:0] WIDTH_RESET  = 10'd512;
   localparam logic [9:0] HEIGHT_RESET = 10'd512;
   localparam logic [9:0] HEIGHT_LIMIT = 10'd512;
   localparam int         ROW_BITS     = 9;

   typedef struct packed {
      logic [7:0] in_c3;
      logic [7:0] in_c2;
      logic [7:0] in_c1;
      logic [7:0] in_c0;
   } req_data_type;

   typedef struct packed {
      logic [7:0] avg_c0;
      logic [7:0] avg_c1;
      logic [7:0] avg_c2;
      logic [7:0] avg_c3;
      logic       last_of_image;
   } rsp_data_type;

   // four 9-bit horizontal pair sums, lane 0 in the low bits
   typedef logic [3:0][8:0] pair_sum_type;

   typedef struct packed {
      pair_sum_type pair;
      logic [3:0]   chan_en;
      logic         last;
   } stage_type;

endpackage
`default_nettype wire

>>> rtl/box_downscale_2x2.sv
// 2x2 box filter downscaler with a pair-sum line buffer
//
// source pixels come in on req_valid/req_ready in raster order, one pixel
// (up to four 8-bit channels) per request. pixel_format picks four, two or
// one used channels; unused channels read as zero on the output.
// for each 2x2 block the mean (sum of four >> 2) per channel goes out on
// rsp_valid/rsp_ready in raster order of the half-size image, and the last
// result of the image carries last_of_image.
// throughput: one request per cycle while rsp_ready stays high; set by the
// single-port line ram, which takes one pair-sum write or read per cycle.
// the result for the request on the odd column of an odd row is registered in
// the read stage (ram read), then in the output register that drives rsp_valid.
// when the receiver stalls, one more result waits in the read stage and then
// req_ready drops until the output register drains.
// reset (synchronous) clears the counters and loads 512x512 rgba; the line
// ram needs no clearing pass, its entries are always written (even row)
// before they are read (odd row). csr writes belong between images.
`default_nettype none
`include "assert_macros.svh"
module box_downscale_2x2
   import bd2x2_pkg::*;
#(
   parameter int MAX_WIDTH = 512
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_ready,
   input  wire req_data_type req_data,
   output      logic         rsp_valid,
   input  wire logic         rsp_ready,
   output      rsp_data_type rsp_data,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [9:0]   csr_wdata
);

   localparam int CW         = $clog2(MAX_WIDTH);   // column counter bits
   localparam int WBW        = CW + 1;              // holds the width bound
   localparam int AW         = CW - 1;              // line ram address bits
   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int WLIM       = MAX_WIDTH - (MAX_WIDTH % 2);

   // configuration registers
   logic [9:0] width_ff, height_ff;
   logic [1:0] format_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         format_ff <= FMT_RGBA;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            CSR_PIXEL_FORMAT: format_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // even, clamped image dimensions
   logic [9:0]     w_even, h_even, h_bound;
   logic [WBW-1:0] w_bound;

   always_comb begin
      w_even = {width_ff[9:1], 1'b0};
      h_even = {height_ff[9:1], 1'b0};
      if (w_even < 10'd2) begin
         w_bound = WBW'(2);
      end else if (32'(w_even) > WLIM) begin
         w_bound = WBW'(WLIM);
      end else begin
         w_bound = WBW'(w_even);
      end
      if (h_even < 10'd2) begin
         h_bound = 10'd2;
      end else if (h_even > HEIGHT_LIMIT) begin
         h_bound = HEIGHT_LIMIT;
      end else begin
         h_bound = h_even;
      end
   end

   // used channel lanes
   logic [3:0] chan_en;

   always_comb begin
      unique case (format_ff)
         FMT_RGBA:       chan_en = 4'b1111;
         FMT_GRAY_ALPHA: chan_en = 4'b0011;
         default:        chan_en = 4'b0001;
      endcase
   end

   // position counters and the held even-column pixel
   logic [CW-1:0]       col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [3:0][7:0]     held_ff, held_in;
   logic                accept, row_end, image_end;
   logic [3:0][7:0]     pix;
   pair_sum_type        pair;

   assign accept    = req_valid && req_ready;
   assign row_end   = {1'b0, col_ff} >= (w_bound - WBW'(1));
   assign image_end = {1'b0, row_ff} >= (h_bound - 10'd1);

   always_comb begin
      pix[0] = chan_en[0] ? req_data.in_c0 : 8'd0;
      pix[1] = chan_en[1] ? req_data.in_c1 : 8'd0;
      pix[2] = chan_en[2] ? req_data.in_c2 : 8'd0;
      pix[3] = chan_en[3] ? req_data.in_c3 : 8'd0;
      for (int c = 0; c < 4; c++) begin
         pair[c] = {1'b0, held_ff[c]} + {1'b0, pix[c]};
      end
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      held_in = held_ff;
      if (accept) begin
         if (!col_ff[0]) begin
            held_in = pix;
         end
         if (row_end) begin
            col_in = '0;
            row_in = image_end ? '0 : row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         held_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         held_ff <= held_in;
      end
   end

   // line ram: even rows store pair sums, odd rows read them back
   pair_sum_type   line_ram [LINE_DEPTH];
   pair_sum_type   rd_data_ff;
   logic [AW-1:0]  slot;
   logic           wr_en, rd_en;

   assign slot  = col_ff[CW-1:1];
   assign wr_en = accept && col_ff[0] && !row_ff[0];
   assign rd_en = accept && col_ff[0] && row_ff[0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_ram[slot] <= pair;
      end
   end

   // read data holds until the next read, which only comes when the
   // read stage is free or moving on
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_ram[slot];
      end
   end

   // read stage and output register
   logic         s1_valid_ff, s1_valid_in;
   stage_type    s1_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;
   logic         out_free;
   logic [3:0][9:0] sum;
   logic [3:0][7:0] avg;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = !s1_valid_ff || out_free;
   assign s1_valid_in = rd_en || (s1_valid_ff && !out_free);
   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         sum[c] = {1'b0, rd_data_ff[c]} + {1'b0, s1_ff.pair[c]};
         avg[c] = s1_ff.chan_en[c] ? sum[c][9:2] : 8'd0;
      end
      rsp_data_in.avg_c0        = avg[0];
      rsp_data_in.avg_c1        = avg[1];
      rsp_data_in.avg_c2        = avg[2];
      rsp_data_in.avg_c3        = avg[3];
      rsp_data_in.last_of_image = s1_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_ff.pair    <= pair;
         s1_ff.chan_en <= chan_en;
         s1_ff.last    <= row_end && image_end;
      end
      if (out_free && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `BD_NEVER(a_no_rd_wr_same_cycle, clock, reset, rd_en && wr_en)
   `BD_ASSERT(a_stall_blocks_input, clock, reset,
      (s1_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
   `BD_ASSERT(a_image_end_clears, clock, reset,
      (accept && row_end && image_end) |=> (row_ff == '0 && col_ff == '0))
   `BD_ASSERT(a_read_stage_loads, clock, reset,
      rd_en |=> s1_valid_ff)

endmodule
`default_nettype wire
